// ===== sv/lmab_pkg.sv =====
// ----------------------------------------------------------------------------
// lmab_pkg
// Shared types and constants of the label map adjacency builder: the word
// codes, the pixel word handed from the line stage to the pair stage, and the
// group of new pairs that one pixel produces.
// ----------------------------------------------------------------------------
package lmab_pkg;

  localparam int LABEL_W     = 8;
  localparam int NB_N        = 4;
  localparam int NB_W        = 2;
  localparam int CFG_W       = 13;
  localparam int GRP_CNT_W   = 3;
  localparam int WIDTH_RESET = 640;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_CLEAR = 1'b1
  } op_t;

  typedef logic [LABEL_W-1:0] label_t;

  // Neighbour order: left, up-left, up, up-right.
  typedef struct packed {
    op_t                 op;
    label_t              lab;
    label_t [NB_N-1:0]   nb;
    logic   [NB_N-1:0]   have;
  } pix_item_t;

  typedef struct packed {
    logic   [GRP_CNT_W-1:0] cnt;
    label_t [NB_N-1:0]      lo;
    label_t [NB_N-1:0]      hi;
  } pair_grp_t;

endpackage

// ===== sv/lmab_line.sv =====
// ----------------------------------------------------------------------------
// lmab_line
// Input stage: raster position, the previous-row line buffer and the left and
// up-left labels. Produces one pixel word with its four neighbours.
// ----------------------------------------------------------------------------
module lmab_line #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_op,
  input  logic                        in_frame_start,
  input  lmab_pkg::label_t            in_pixel_label,
  input  logic [lmab_pkg::CFG_W-1:0]  image_width,
  input  logic                        clr_busy,
  output logic                        item_v,
  output lmab_pkg::pix_item_t         item,
  input  logic                        item_take
);
  import lmab_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);

  label_t          lbuf [MAX_WIDTH];

  logic [CW-1:0]   col_r;
  logic            row_nz_r;
  label_t          left_r;
  label_t          upleft_r;
  logic            slot_v_r;

  op_t             op_r;
  label_t          lab_r;
  label_t          left_q_r;
  logic [NB_N-1:0] have_r;
  label_t          up_q_r;
  label_t          ur_q_r;

  logic [WW-1:0]   w_eff;
  logic            accept;
  logic            pix_acc;
  logic [CW-1:0]   col;
  logic            row_nz;
  logic [WW-1:0]   col_inc;
  logic            wrap;
  logic [CW-1:0]   ur_addr;
  logic [NB_N-1:0] have;

  always_comb begin
    if (image_width == '0) begin
      w_eff = WW'(1);
    end else if (int'(image_width) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(image_width);
    end
  end

  assign in_stall = clr_busy || (slot_v_r && !item_take);
  assign accept   = in_valid && !in_stall;
  assign pix_acc  = accept && (op_t'(in_op) == OP_PIXEL);

  assign col     = in_frame_start ? '0 : col_r;
  assign row_nz  = in_frame_start ? 1'b0 : row_nz_r;
  assign col_inc = WW'(col) + WW'(1);
  assign wrap    = (col_inc >= w_eff);
  assign ur_addr = wrap ? col : CW'(col_inc);

  assign have[0] = (col != '0);
  assign have[1] = row_nz && (col != '0);
  assign have[2] = row_nz;
  assign have[3] = row_nz && !wrap;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r    <= '0;
      row_nz_r <= 1'b0;
      left_r   <= '0;
      upleft_r <= '0;
      slot_v_r <= 1'b0;
    end else begin
      if (pix_acc) begin
        col_r    <= wrap ? '0 : CW'(col_inc);
        row_nz_r <= wrap ? 1'b1 : row_nz;
        left_r   <= in_pixel_label;
      end
      // The up label of this pixel is the up-left label of the next one.
      if (item_take && slot_v_r && (op_r == OP_PIXEL)) begin
        upleft_r <= up_q_r;
      end
      if (accept) begin
        slot_v_r <= 1'b1;
      end else if (item_take) begin
        slot_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r     <= op_t'(in_op);
      lab_r    <= in_pixel_label;
      left_q_r <= left_r;
      have_r   <= have;
    end
  end

  // Line buffer: the old entry is read in the same cycle that it is replaced.
  always_ff @(posedge clk) begin
    if (pix_acc) begin
      up_q_r     <= lbuf[col];
      ur_q_r     <= lbuf[ur_addr];
      lbuf[col]  <= in_pixel_label;
    end
  end

  assign item_v     = slot_v_r;
  assign item.op    = op_r;
  assign item.lab   = lab_r;
  assign item.nb[0] = left_q_r;
  assign item.nb[1] = upleft_r;
  assign item.nb[2] = up_q_r;
  assign item.nb[3] = ur_q_r;
  assign item.have  = have_r;

endmodule

// ===== sv/lmab_pair.sv =====
// ----------------------------------------------------------------------------
// lmab_pair
// Pair stage: the adjacency bitmap memory with its read-test-set pipeline,
// the collection of the new pairs of one pixel and the clearing sweep.
// ----------------------------------------------------------------------------
module lmab_pair #(
  parameter int MAX_LABELS = 256
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 item_v,
  input  lmab_pkg::pix_item_t  item,
  output logic                 item_take,
  output logic                 clr_busy,
  output logic                 grp_v,
  output lmab_pkg::pair_grp_t  grp,
  input  logic                 grp_ready
);
  import lmab_pkg::*;

  localparam int LBL_N = (MAX_LABELS > 256) ? 256 : MAX_LABELS;
  localparam int LBL_W = $clog2(LBL_N);

  // One row per smaller label, one bit per larger label.
  logic [LBL_N-1:0]  bmap [LBL_N];

  logic [NB_N-1:0]   mask_r;
  label_t            px_lab_r;
  label_t [NB_N-1:0] px_nb_r;

  logic              t_v_r;
  logic              t_fin_r;
  label_t            t_lo_r;
  label_t            t_hi_r;
  logic [LBL_N-1:0]  rd_q_r;
  logic              fwd_r;
  logic [LBL_N-1:0]  fwd_data_r;

  logic              clr_active_r;
  logic [LBL_W-1:0]  clr_row_r;
  pair_grp_t         coll_r;
  logic              coll_done_r;

  logic [NB_W-1:0]   k_sel;
  logic [NB_N-1:0]   rest_mask;
  label_t            nbk;
  label_t            pick_lo;
  label_t            pick_hi;
  logic              blk;
  logic              issue;
  logic              px_free;
  logic              take_pix;
  logic              take_clr;
  logic [NB_N-1:0]   cand;
  logic [LBL_N-1:0]  t_row;
  logic              t_new;
  logic              t_close;
  logic              we;
  logic [LBL_W-1:0]  wr_row;
  logic [LBL_N-1:0]  wdata;
  logic [LBL_W-1:0]  rd_row;
  pair_grp_t         g_nxt;

  // Lowest pending neighbour goes first, keeping the left, up-left, up,
  // up-right order of the results.
  always_comb begin
    k_sel = '0;
    for (int i = NB_N - 1; i >= 0; i--) begin
      if (mask_r[i]) begin
        k_sel = NB_W'(i);
      end
    end
  end

  assign rest_mask = mask_r & ~(NB_N'(1) << k_sel);
  assign nbk       = px_nb_r[k_sel];
  assign pick_lo   = (px_lab_r < nbk) ? px_lab_r : nbk;
  assign pick_hi   = (px_lab_r < nbk) ? nbk : px_lab_r;
  assign rd_row    = pick_lo[LBL_W-1:0];

  assign t_close = t_v_r && t_fin_r;
  // No new tests while a finished group still waits for the output stage.
  assign blk     = (coll_done_r && !grp_ready) || (t_close && !grp_ready);
  assign issue   = (mask_r != '0) && !clr_active_r && !blk;
  assign px_free = (mask_r == '0) || (issue && (rest_mask == '0));

  assign take_pix  = item_v && (item.op == OP_PIXEL) && px_free && !clr_active_r;
  assign take_clr  = item_v && (item.op == OP_CLEAR) && (mask_r == '0) && !t_v_r
                     && !clr_active_r;
  assign item_take = take_pix || take_clr;
  assign clr_busy  = clr_active_r;

  always_comb begin
    for (int i = 0; i < NB_N; i++) begin
      cand[i] = item.have[i] && (item.nb[i] != item.lab)
                && (int'(item.lab) < MAX_LABELS) && (int'(item.nb[i]) < MAX_LABELS);
    end
  end

  // Test stage: the row may have been rewritten in the cycle it was read.
  assign t_row = fwd_r ? fwd_data_r : rd_q_r;
  assign t_new = t_v_r && !t_row[t_hi_r[LBL_W-1:0]];

  always_comb begin
    if (clr_active_r) begin
      we     = 1'b1;
      wr_row = clr_row_r;
      wdata  = '0;
    end else begin
      we     = t_new;
      wr_row = t_lo_r[LBL_W-1:0];
      wdata  = t_row | (LBL_N'(1) << t_hi_r[LBL_W-1:0]);
    end
  end

  always_comb begin
    g_nxt = coll_r;
    if (t_new) begin
      g_nxt.lo[coll_r.cnt[NB_W-1:0]] = t_lo_r;
      g_nxt.hi[coll_r.cnt[NB_W-1:0]] = t_hi_r;
      g_nxt.cnt                      = coll_r.cnt + GRP_CNT_W'(1);
    end
  end

  assign grp_v = (t_close && (g_nxt.cnt != '0)) || coll_done_r;
  assign grp   = g_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r       <= '0;
      t_v_r        <= 1'b0;
      clr_active_r <= 1'b1;
      clr_row_r    <= '0;
      coll_r       <= '0;
      coll_done_r  <= 1'b0;
    end else begin
      if (take_pix) begin
        mask_r <= cand;
      end else if (issue) begin
        mask_r <= rest_mask;
      end
      t_v_r <= issue;

      if (take_clr) begin
        clr_active_r <= 1'b1;
        clr_row_r    <= '0;
      end else if (clr_active_r) begin
        if (clr_row_r == LBL_W'(LBL_N - 1)) begin
          clr_active_r <= 1'b0;
        end
        clr_row_r <= clr_row_r + LBL_W'(1);
      end

      if (t_close) begin
        if ((g_nxt.cnt != '0) && !grp_ready) begin
          coll_r      <= g_nxt;
          coll_done_r <= 1'b1;
        end else begin
          coll_r.cnt  <= '0;
          coll_done_r <= 1'b0;
        end
      end else if (coll_done_r && grp_ready) begin
        coll_r.cnt  <= '0;
        coll_done_r <= 1'b0;
      end else if (t_v_r) begin
        coll_r <= g_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_pix) begin
      px_lab_r <= item.lab;
      px_nb_r  <= item.nb;
    end
    if (issue) begin
      t_fin_r    <= (rest_mask == '0);
      t_lo_r     <= pick_lo;
      t_hi_r     <= pick_hi;
      fwd_r      <= we && (wr_row == rd_row);
      fwd_data_r <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_q_r <= bmap[rd_row];
    end
    if (we) begin
      bmap[wr_row] <= wdata;
    end
  end

endmodule

// ===== sv/lmab_ser.sv =====
// ----------------------------------------------------------------------------
// lmab_ser
// Output stage: holds the group of new pairs of one pixel and hands them out
// one word at a time, marking the final pair of the group.
// ----------------------------------------------------------------------------
module lmab_ser (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 grp_v,
  input  lmab_pkg::pair_grp_t  grp,
  output logic                 grp_ready,
  output logic                 out_valid,
  input  logic                 out_stall,
  output lmab_pkg::label_t     out_label_low,
  output lmab_pkg::label_t     out_label_high,
  output logic                 out_last_pair
);
  import lmab_pkg::*;

  logic            ser_v_r;
  pair_grp_t       grp_r;
  logic [NB_W-1:0] idx_r;
  logic            take;
  logic            last;

  assign last      = ((GRP_CNT_W'(idx_r) + GRP_CNT_W'(1)) == grp_r.cnt);
  assign take      = ser_v_r && !out_stall;
  assign grp_ready = !ser_v_r || (take && last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ser_v_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      if (grp_v && grp_ready) begin
        ser_v_r <= 1'b1;
        idx_r   <= '0;
      end else if (take) begin
        if (last) begin
          ser_v_r <= 1'b0;
        end
        idx_r <= idx_r + NB_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (grp_v && grp_ready) begin
      grp_r <= grp;
    end
  end

  assign out_valid      = ser_v_r;
  assign out_label_low  = grp_r.lo[idx_r];
  assign out_label_high = grp_r.hi[idx_r];
  assign out_last_pair  = last;

endmodule

// ===== sv/label_map_adjacency_builder.sv =====
// ----------------------------------------------------------------------------
// label_map_adjacency_builder
// Builds the 8-connected region adjacency of a superpixel label map fed in
// raster order and reports every newly found pair of touching labels once.
// ----------------------------------------------------------------------------
// Each input word is either a label pixel or a request to clear the adjacency
// bitmap. A pixel is compared with its left, up-left, up and up-right
// neighbours; every pair of different labels below MAX_LABELS that has not
// been seen since the last clear comes out as one word, smaller label first,
// in that neighbour order, with last_pair set on the final new pair of that
// pixel. A pixel that finds nothing new gives no output at all. Every
// candidate pair is one test on the adjacency bitmap memory, which is read,
// tested and written back in a two-stage pipeline; a pixel makes one test per
// neighbour that exists and carries a different label, and none when it has
// no candidate neighbours. The pairs of a pixel are handed on together once
// its last test is done, and the next pixel is taken while the previous one's
// pairs are still being handed out. The bitmap holds one row per smaller
// label; after reset and after every clear word it is wiped one row per
// cycle over all of its rows (MAX_LABELS of them, 256 at the default, never
// more than 256), and no input word is taken during that sweep. The row
// width is set through cfg_wr_data and may only be changed while the block is
// idle; a frame_start word restarts the position at the top-left corner.
// ----------------------------------------------------------------------------
module label_map_adjacency_builder #(
  parameter int MAX_LABELS = 256,
  parameter int MAX_WIDTH  = 4096
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [lmab_pkg::CFG_W-1:0]  cfg_wr_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_op,
  input  logic                        in_frame_start,
  input  lmab_pkg::label_t            in_pixel_label,
  output logic                        out_valid,
  input  logic                        out_stall,
  output lmab_pkg::label_t            out_label_low,
  output lmab_pkg::label_t            out_label_high,
  output logic                        out_last_pair
);
  import lmab_pkg::*;

  logic [CFG_W-1:0] image_width_r;

  logic             item_v;
  pix_item_t        item;
  logic             item_take;
  logic             clr_busy;
  logic             grp_v;
  pair_grp_t        grp;
  logic             grp_ready;

  // The width register is taken as written; the line stage limits it to the
  // range the line buffer supports.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r <= CFG_W'(WIDTH_RESET);
    end else if (cfg_wr_en) begin
      image_width_r <= cfg_wr_data;
    end
  end

  // Position tracking and the previous-row line buffer.
  lmab_line #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_op          (in_op),
    .in_frame_start (in_frame_start),
    .in_pixel_label (in_pixel_label),
    .image_width    (image_width_r),
    .clr_busy       (clr_busy),
    .item_v         (item_v),
    .item           (item),
    .item_take      (item_take)
  );

  // Adjacency bitmap with its read-test-set pipeline and clearing sweep.
  lmab_pair #(
    .MAX_LABELS (MAX_LABELS)
  ) u_pair (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_v    (item_v),
    .item      (item),
    .item_take (item_take),
    .clr_busy  (clr_busy),
    .grp_v     (grp_v),
    .grp       (grp),
    .grp_ready (grp_ready)
  );

  // Hands the pairs of one pixel out one word at a time.
  lmab_ser u_ser (
    .clk            (clk),
    .rst_n          (rst_n),
    .grp_v          (grp_v),
    .grp            (grp),
    .grp_ready      (grp_ready),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_label_low  (out_label_low),
    .out_label_high (out_label_high),
    .out_last_pair  (out_last_pair)
  );

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the label map adjacency builder.
// ----------------------------------------------------------------------------
// Label maps of several row widths are streamed into the block. Each accepted
// input word goes through a behavioural copy of the block, which lists the new
// adjacent pairs that the word should produce. Every pair word that leaves the
// block is then compared, field by field, with the oldest pair still due.
// Both channels idle at random, and the row width is changed only while the
// block is idle.
// ----------------------------------------------------------------------------
module testbench;
  import lmab_pkg::*;

  localparam int MAX_W          = 4096;
  localparam int ROW_SAT        = 4095;
  localparam int LABEL_COUNT    = 256;
  localparam int WATCHDOG_LIMIT = 2000;
  // The pause before a width change covers the bitmap sweep that follows a
  // clear word, as well as the pipeline of a pixel that finds no new pair.
  localparam int IDLE_PAUSE     = 300;
  localparam int DRAIN_CYCLES   = 20;
  localparam int RANDOM_WORDS   = 280;

  typedef struct {
    op_t    op;
    logic   frame_start;
    label_t label;
  } pix_word_t;

  typedef struct {
    label_t lo;
    label_t hi;
    logic   last;
  } pair_word_t;

  // Every input of the block starts at a known value.
  logic             clk            = 1'b0;
  logic             rst_n          = 1'b0;
  logic             cfg_wr_en      = 1'b0;
  logic [CFG_W-1:0] cfg_wr_data    = '0;
  logic             in_valid       = 1'b0;
  logic             in_stall;
  op_t              in_op          = OP_PIXEL;
  logic             in_frame_start = 1'b0;
  label_t           in_pixel_label = '0;
  logic             out_valid;
  logic             out_stall      = 1'b0;
  label_t           out_label_low;
  label_t           out_label_high;
  logic             out_last_pair;

  label_map_adjacency_builder dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_op          (in_op),
    .in_frame_start (in_frame_start),
    .in_pixel_label (in_pixel_label),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_label_low  (out_label_low),
    .out_label_high (out_label_high),
    .out_last_pair  (out_last_pair)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Behavioural copy of the block: the row width, the line buffer holding the
  // row above, the left and up-left labels, the raster position and the
  // bitmap of pairs already reported since the last clear.
  // --------------------------------------------------------------------------
  logic [CFG_W-1:0]       width_reg;
  label_t                 line_buf [MAX_W];
  label_t                 left_lab;
  label_t                 upleft_lab;
  int                     col_pos;
  int                     row_pos;
  logic [LABEL_COUNT-1:0] pair_seen [LABEL_COUNT];

  pix_word_t  words_to_send [$];
  pair_word_t pairs_due [$];

  int fail_count    = 0;
  int pixels_taken  = 0;
  int clears_taken  = 0;
  int pairs_checked = 0;
  int widths_used   = 0;

  function automatic void append_word(pix_word_t w);
    words_to_send = {words_to_send, w};
  endfunction

  function automatic void append_due(pair_word_t p);
    pairs_due = {pairs_due, p};
  endfunction

  // A width of zero acts as one pixel per row, and anything beyond the line
  // buffer saturates to its full length.
  function automatic int row_width();
    if (width_reg == 0) return 1;
    if (width_reg > MAX_W) return MAX_W;
    return int'(width_reg);
  endfunction

  // Works out the pair words that one accepted input word should produce and
  // appends them to the list of pairs due, then advances the position.
  function automatic void find_new_pairs(pix_word_t w);
    int         w_eff;
    int         col;
    label_t     up;
    label_t     nb [4];
    logic       have [4];
    label_t     lo;
    label_t     hi;
    pair_word_t found [$];
    pair_word_t one;
    if (w.op == OP_CLEAR) begin
      // A clear wipes the bitmap only; the position and labels stay as they are.
      foreach (pair_seen[i]) pair_seen[i] = '0;
      return;
    end
    if (w.frame_start) begin
      col_pos = 0;
      row_pos = 0;
    end
    w_eff = row_width();
    col   = col_pos;
    up    = line_buf[col];
    // Neighbours in the order the block visits them: left, up-left, up and
    // up-right. The up-right pixel exists only when the row goes on past col.
    nb[0]   = left_lab;
    have[0] = col > 0;
    nb[1]   = upleft_lab;
    have[1] = row_pos > 0 && col > 0;
    nb[2]   = up;
    have[2] = row_pos > 0;
    have[3] = row_pos > 0 && col + 1 < w_eff;
    nb[3]   = have[3] ? line_buf[col + 1] : '0;
    for (int k = 0; k < 4; k++) begin
      if (have[k] && nb[k] != w.label) begin
        lo = (w.label < nb[k]) ? w.label : nb[k];
        hi = (w.label < nb[k]) ? nb[k] : w.label;
        // With 8-bit labels and 256 labels in the bitmap, every pair fits.
        if (!pair_seen[lo][hi]) begin
          pair_seen[lo][hi] = 1'b1;
          one.lo   = lo;
          one.hi   = hi;
          one.last = 1'b0;
          found    = {found, one};
        end
      end
    end
    if (found.size() > 0) found[found.size() - 1].last = 1'b1;
    foreach (found[i]) append_due(found[i]);
    upleft_lab    = up;
    line_buf[col] = w.label;
    left_lab      = w.label;
    // The row ends as soon as the next column would reach the width, even if
    // the width was lowered while the row was under way.
    if (col + 1 >= w_eff) begin
      col_pos = 0;
      if (row_pos < ROW_SAT) row_pos++;
    end else begin
      col_pos = col + 1;
    end
  endfunction

  // Both sides draw a random wait before each word, except during calm
  // stretches in which they never hold back.
  function automatic int idle_draw(bit calm);
    return calm ? 0 : int'($urandom_range(0, 5));
  endfunction

  // --------------------------------------------------------------------------
  // Driver: takes input words from the queue of pending words. A word stays on
  // the pins, unchanged, until it has been accepted; its effect is predicted
  // at the very edge at which it is taken.
  // --------------------------------------------------------------------------
  pix_word_t cur_word;
  int        gap_left = 0;
  bit        calm_in  = 1'b0;
  bit        word_taken;

  always @(posedge clk) begin
    if (rst_n) begin
      word_taken = in_valid && !in_stall;
      if (word_taken) begin
        find_new_pairs(cur_word);
        if (cur_word.op == OP_CLEAR) clears_taken++;
        else pixels_taken++;
        gap_left = idle_draw(calm_in);
        if ($urandom_range(0, 39) == 0) calm_in = !calm_in;
      end
      if (in_valid && !word_taken) begin
        // Stalled: the word is held as it is.
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (words_to_send.size() > 0) begin
        cur_word       = words_to_send.pop_front();
        in_valid       <= 1'b1;
        in_op          <= cur_word.op;
        in_frame_start <= cur_word.frame_start;
        in_pixel_label <= cur_word.label;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: checks every accepted pair word against the oldest one due, then
  // draws how long to stall before the next word.
  // --------------------------------------------------------------------------
  int         stall_left = 0;
  bit         calm_out   = 1'b0;
  pair_word_t oldest_due;

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pairs_due.size() == 0) begin
        $error("unexpected pair word: label_low %0d, label_high %0d, last_pair %0b",
               out_label_low, out_label_high, out_last_pair);
        fail_count++;
      end else begin
        oldest_due = pairs_due.pop_front();
        pairs_checked++;
        if (out_label_low !== oldest_due.lo) begin
          $error("label_low: expected %0d, actual %0d", oldest_due.lo, out_label_low);
          fail_count++;
        end
        if (out_label_high !== oldest_due.hi) begin
          $error("label_high: expected %0d, actual %0d", oldest_due.hi, out_label_high);
          fail_count++;
        end
        if (out_last_pair !== oldest_due.last) begin
          $error("last_pair: expected %0b, actual %0b", oldest_due.last, out_last_pair);
          fail_count++;
        end
      end
      stall_left = idle_draw(calm_out);
      if ($urandom_range(0, 39) == 0) calm_out = !calm_out;
    end else if (stall_left > 0) begin
      stall_left--;
    end
    out_stall <= (stall_left != 0);
  end

  // --------------------------------------------------------------------------
  // Watchdog: while work is outstanding, some word must move on one of the
  // two channels within the limit. The longest quiet spell of a correct block
  // is the bitmap sweep.
  // --------------------------------------------------------------------------
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst_n && (words_to_send.size() > 0 || in_valid || pairs_due.size() > 0)) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles, %0d pair words still due",
                 quiet_cycles, pairs_due.size());
        $display("CHECKS FAILED");
        $finish;
      end
    end else begin
      quiet_cycles = 0;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  function automatic void push_pixel(logic fs, label_t lab);
    pix_word_t w;
    w.op          = OP_PIXEL;
    w.frame_start = fs;
    w.label       = lab;
    append_word(w);
  endfunction

  // The frame-start flag and the label of a clear word are ignored by the
  // block, so they carry random values.
  function automatic void push_clear();
    pix_word_t w;
    w.op          = OP_CLEAR;
    w.frame_start = 1'($urandom);
    w.label       = 8'($urandom);
    append_word(w);
  endfunction

  // Sampled away from the rising edge, so that the driver's update at that
  // edge has settled.
  task automatic wait_idle();
    while (words_to_send.size() != 0 || in_valid || pairs_due.size() != 0)
      @(negedge clk);
  endtask

  // The width is only written once every word has been taken and every pair
  // has come out, after a pause long enough for a silent pixel or a sweep.
  task automatic program_width(input logic [CFG_W-1:0] value);
    wait_idle();
    repeat (IDLE_PAUSE) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    width_reg = value;
    widths_used++;
  endtask

  int     random_sent;
  int     new_w;
  int     n_pal;
  int     n_words;
  int     pick;
  bit     keep_pos;
  label_t palette [6];

  initial begin
    width_reg  = WIDTH_RESET;
    left_lab   = '0;
    upleft_lab = '0;
    col_pos    = 0;
    row_pos    = 0;
    foreach (line_buf[i]) line_buf[i] = '0;
    foreach (pair_seen[i]) pair_seen[i] = '0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Out of reset, at the default width: the top row only, so the left
    // neighbour is the only one, with the extreme labels.
    push_pixel(1'b1, 8'd0);
    push_pixel(1'b0, 8'd255);
    push_pixel(1'b0, 8'd255);
    push_pixel(1'b0, 8'd128);
    push_pixel(1'b0, 8'd1);

    // Three columns: every neighbour direction, a pixel finding four new pairs
    // at once, pairs already known, equal labels, a clear mid-row that leaves
    // the position alone, and a frame start in the middle of a frame.
    program_width(13'd3);
    push_pixel(1'b1, 8'd10);
    push_pixel(1'b0, 8'd20);
    push_pixel(1'b0, 8'd40);
    push_pixel(1'b0, 8'd30);
    push_pixel(1'b0, 8'd255);
    push_pixel(1'b0, 8'd0);
    push_pixel(1'b0, 8'd255);
    push_pixel(1'b0, 8'd10);
    push_clear();
    push_pixel(1'b0, 8'd10);
    push_pixel(1'b0, 8'd7);
    push_pixel(1'b1, 8'd8);
    push_pixel(1'b0, 8'd9);

    // A width of zero behaves as one column: only the pixel above counts.
    program_width(13'd0);
    push_pixel(1'b1, 8'd3);
    push_pixel(1'b0, 8'd3);
    push_pixel(1'b0, 8'd5);
    push_pixel(1'b0, 8'd200);

    program_width(13'd1);
    push_pixel(1'b1, 8'd1);
    push_pixel(1'b0, 8'd2);
    push_pixel(1'b0, 8'd2);
    push_pixel(1'b0, 8'd1);

    // Width lowered in the middle of a row: the second row has gone past the
    // new width, so it ends at once and the next row is three wide.
    program_width(13'd6);
    push_pixel(1'b1, 8'd11);
    for (int c = 1; c < 10; c++) push_pixel(1'b0, 8'(11 + c % 4));
    program_width(13'd3);
    for (int c = 0; c < 5; c++) push_pixel(1'b0, 8'(20 + c % 3));

    // Oversized width saturates to the full line buffer, so a short stretch of
    // pixels all stays on the top row.
    program_width(13'd8191);
    push_pixel(1'b1, 8'd60);
    push_pixel(1'b0, 8'd61);
    push_pixel(1'b0, 8'd62);
    push_pixel(1'b0, 8'd60);
    push_pixel(1'b0, 8'd63);

    // Random frames. Most words are pixels drawn from a small palette, so that
    // regions touch again and again and the bitmap fills up; the rest are
    // labels from the whole range, clear words and stray frame starts.
    random_sent = 0;
    while (random_sent < RANDOM_WORDS) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) new_w = $urandom_range(0, 1);
      else if (pick == 1) new_w = $urandom_range(13, 40);
      else new_w = $urandom_range(2, 12);
      // Only a lower width may carry on the frame that is under way; a wider
      // row would look up line buffer entries that were never filled.
      keep_pos = new_w != 0 && new_w <= row_width() && $urandom_range(0, 3) == 0;
      program_width(13'(new_w));
      n_pal = $urandom_range(2, 6);
      for (int k = 0; k < 6; k++) palette[k] = 8'($urandom_range(0, 255));
      n_words = $urandom_range(25, 60);
      if (!keep_pos) begin
        push_pixel(1'b1, palette[0]);
        random_sent++;
      end
      for (int i = 0; i < n_words; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 3) push_clear();
        else if (pick < 5) push_pixel(1'b1, 8'($urandom));
        else if (pick < 15) push_pixel(1'b0, 8'($urandom));
        else push_pixel(1'b0, palette[$urandom_range(0, n_pal - 1)]);
        random_sent++;
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Run covered %0d pixel words and %0d clear words at %0d row widths,",
             pixels_taken, clears_taken, widths_used);
    $display("with %0d pair words checked and %0d mismatches.", pairs_checked, fail_count);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
